FILE: rtl/core/cbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants, codes and control structs of the counting Bloom filter.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int NUM_COUNTERS = 1024;
    localparam int MAX_HASHES   = 4;
    localparam int KEY_BITS     = 32;
    localparam int COUNT_BITS   = 16;
    localparam int HASH_W       = 64;

    localparam int CIDX_W      = $clog2(NUM_COUNTERS);
    localparam int MOD_W       = CIDX_W + 1;
    localparam int ROW_W       = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int BIT_IDX_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CONST_ADDR_W = ROW_W + BIT_IDX_W;
    localparam int CONST_DEPTH = MAX_HASHES * KEY_BITS;

    // Configuration register widths
    localparam int NP_W = 11;
    localparam int NH_W = 3;
    localparam int KL_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POSITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH    = 2'd2;

    // Item field widths
    localparam int OPC_W   = 2;
    localparam int CROW_W  = 2;
    localparam int CCOL_W  = 5;
    localparam int MINC_W  = 16;
    localparam int NZC_W   = 3;

    // Remainder unit: bits of the hash consumed per cycle
    localparam int MOD_DIGIT  = 4;
    localparam int MOD_CYCLES = HASH_W / MOD_DIGIT;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CNT_QUERY = 2'd0,
        CNT_ADD   = 2'd1,
        CNT_CLEAR = 2'd2
    } t_cnt_cmd;

    typedef struct packed {
        logic                    start;
        logic [ROW_W-1:0]        row;
        logic [KEY_BITS-1:0]     key;
        logic [KL_W-1:0]         len;
        logic [MOD_W-1:0]        modulus;
        logic                    wr_en;
        logic [CONST_ADDR_W-1:0] wr_addr;
        logic [HASH_W-1:0]       wr_data;
    } t_hash_req;

    typedef struct packed {
        logic              done;
        logic [CIDX_W-1:0] index;
    } t_hash_rsp;

    typedef struct packed {
        logic              valid;
        t_cnt_cmd          cmd;
        logic [CIDX_W-1:0] index;
    } t_cnt_req;

    typedef struct packed {
        logic                  ready;
        logic                  done;
        logic [COUNT_BITS-1:0] value;
        logic                  sat;
    } t_cnt_rsp;

endpackage
`default_nettype wire

FILE: rtl/core/cbf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface cbf_in_if;
    logic                          valid;
    logic                          ready;
    logic [cbf_pkg::OPC_W-1:0]     opcode;
    logic [cbf_pkg::KEY_BITS-1:0]  key_bits;
    logic [cbf_pkg::CROW_W-1:0]    const_row;
    logic [cbf_pkg::CCOL_W-1:0]    const_column;
    logic [cbf_pkg::HASH_W-1:0]    const_value;

    modport source (output valid, opcode, key_bits, const_row, const_column, const_value,
                    input ready);
    modport sink   (input valid, opcode, key_bits, const_row, const_column, const_value,
                    output ready);
endinterface

interface cbf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        present;
    logic [cbf_pkg::MINC_W-1:0]  min_count;
    logic [cbf_pkg::NZC_W-1:0]   nonzero_count;
    logic                        saturated;

    modport source (output valid, present, min_count, nonzero_count, saturated,
                    input ready);
    modport sink   (input valid, present, min_count, nonzero_count, saturated,
                    output ready);
endinterface

interface cbf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbf_pkg::CFG_IDX_W-1:0]   index;
    logic [cbf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cbf_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_hash
// H3 row hash: XOR of stored constants over set key bits, one constant per
// cycle from the constant memory, then a remainder by the modulus, four bits
// of the hash per cycle.
// ----------------------------------------------------------------------------
module cbf_hash (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cbf_pkg::t_hash_req i_req,
    output cbf_pkg::t_hash_rsp      o_rsp
);
    import cbf_pkg::*;

    typedef enum logic [3:0] {
        H_IDLE  = 4'b0001,
        H_FETCH = 4'b0010,
        H_MOD   = 4'b0100,
        H_DONE  = 4'b1000
    } t_hstate;

    t_hstate                 r_state;
    logic [HASH_W-1:0]       r_const_mem [CONST_DEPTH];
    logic [HASH_W-1:0]       r_rd_data;
    logic [ROW_W-1:0]        r_row;
    logic [KEY_BITS-1:0]     r_key;
    logic [KL_W-1:0]         r_len;
    logic [MOD_W-1:0]        r_mod;
    logic [KL_W-1:0]         r_bit;
    logic                    r_take;
    logic [HASH_W-1:0]       r_hash;
    logic [CIDX_W-1:0]       r_rem;
    logic [MOD_CNT_W-1:0]    r_cnt;

    logic [CONST_ADDR_W-1:0] rd_addr;
    logic [CIDX_W-1:0]       n_rem;

    assign rd_addr = {r_row, r_bit[BIT_IDX_W-1:0]};

    // Constant memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_const_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_const_mem[rd_addr];
    end

    // Restoring remainder, MOD_DIGIT hash bits per cycle, MSB first
    always_comb begin
        logic [MOD_W-1:0]  t;
        logic [CIDX_W-1:0] rem;
        rem = r_rem;
        for (int i = 0; i < MOD_DIGIT; i++) begin
            t = {rem, r_hash[HASH_W-1-i]};
            if (t >= r_mod) begin
                t = t - r_mod;
            end
            rem = t[CIDX_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_take  <= 1'b0;
        end else begin
            unique case (r_state)
                H_IDLE: begin
                    if (i_req.start) begin
                        r_row   <= i_req.row;
                        r_key   <= i_req.key;
                        r_len   <= i_req.len;
                        r_mod   <= i_req.modulus;
                        r_bit   <= '0;
                        r_take  <= 1'b0;
                        r_hash  <= '0;
                        r_state <= H_FETCH;
                    end
                end
                H_FETCH: begin
                    // Data read last cycle arrives now; fold it in if its key bit was set
                    if (r_take) begin
                        r_hash <= r_hash ^ r_rd_data;
                    end
                    r_take <= (r_bit < r_len) && r_key[r_bit[BIT_IDX_W-1:0]];
                    if (r_bit == r_len) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= H_MOD;
                    end else begin
                        r_bit <= r_bit + KL_W'(1);
                    end
                end
                H_MOD: begin
                    r_rem  <= n_rem;
                    r_hash <= r_hash << MOD_DIGIT;
                    r_cnt  <= r_cnt + MOD_CNT_W'(1);
                    if (r_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                        r_state <= H_DONE;
                    end
                end
                H_DONE: begin
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = (r_state == H_DONE);
    assign o_rsp.index = r_rem;

endmodule
`default_nettype wire

FILE: rtl/core/cbf_counters.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_counters
// Counter memory with read-modify-write for add, plain read for query and
// a one-entry-per-cycle clearing sweep after reset and on clear.
// ----------------------------------------------------------------------------
module cbf_counters (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cbf_pkg::t_cnt_req i_req,
    output cbf_pkg::t_cnt_rsp      o_rsp
);
    import cbf_pkg::*;

    typedef enum logic [2:0] {
        C_CLEAR  = 3'b001,
        C_IDLE   = 3'b010,
        C_ACCESS = 3'b100
    } t_cstate;

    t_cstate               r_state;
    logic [COUNT_BITS-1:0] r_cnt_mem [NUM_COUNTERS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [CIDX_W-1:0]     r_clr_addr;
    logic [CIDX_W-1:0]     r_idx;
    logic                  r_add;

    logic                  wr_en;
    logic [CIDX_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  at_max;

    assign at_max = (r_rd_data == COUNT_MAX);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rd_data + COUNT_BITS'(1);
        if (r_state == C_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (r_state == C_ACCESS) begin
            wr_en = r_add && !at_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cnt_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_cnt_mem[i_req.index];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= C_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                C_CLEAR: begin
                    r_clr_addr <= r_clr_addr + CIDX_W'(1);
                    if (r_clr_addr == CIDX_W'(NUM_COUNTERS - 1)) begin
                        r_state <= C_IDLE;
                    end
                end
                C_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.cmd == CNT_CLEAR) begin
                            r_clr_addr <= '0;
                            r_state    <= C_CLEAR;
                        end else begin
                            r_idx   <= i_req.index;
                            r_add   <= (i_req.cmd == CNT_ADD);
                            r_state <= C_ACCESS;
                        end
                    end
                end
                C_ACCESS: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.ready = (r_state == C_IDLE);
    assign o_rsp.done  = (r_state == C_ACCESS);
    assign o_rsp.value = r_rd_data;
    assign o_rsp.sat   = r_add && at_max;

endmodule
`default_nettype wire

FILE: rtl/core/counting_bloom_filter_h3_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_bloom_filter_h3_core
// Counting Bloom filter with H3 hashing: add, query, clear and constant load.
// ----------------------------------------------------------------------------
// Add/query: per hash row, a fetch pass over the key bits, the remainder pass
//   and a handoff to the counter access (read-modify-write for add, read for
//   query); the rows run one after another, one item at a time.
// Clear: one counter written per cycle. Load: the constant is written on accept.
// Reset: a clearing pass zeroes the counters; no item is taken meanwhile,
//   configuration writes are. Registers reset to 1024, 4, 32.
// ----------------------------------------------------------------------------
module counting_bloom_filter_h3_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbf_in_if.sink     i_item,
    cbf_out_if.source  o_result,
    cbf_cfg_if.sink    i_cfg
);
    import cbf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HSTART = 6'b000010,
        S_HWAIT  = 6'b000100,
        S_CSTART = 6'b001000,
        S_CWAIT  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [NH_W-1:0]       r_k, n_k;
    logic [CIDX_W-1:0]     r_index, n_index;
    logic [COUNT_BITS-1:0] r_min, n_min;
    logic [NZC_W-1:0]      r_nz, n_nz;
    logic                  r_sat, n_sat;

    logic [NP_W-1:0]       r_num_positions;
    logic [NH_W-1:0]       r_num_hashes;
    logic [KL_W-1:0]       r_key_length;

    logic                  r_out_valid;
    logic                  r_present;
    logic [MINC_W-1:0]     r_min_count;
    logic [NZC_W-1:0]      r_nonzero_count;
    logic                  r_saturated;

    logic                  accept;
    logic                  out_free;
    logic                  last_row;
    t_opcode               in_op;
    logic [KL_W-1:0]       len_eff;
    logic [MOD_W-1:0]      mod_eff;
    logic [NH_W-1:0]       k_eff;

    t_hash_req             hash_req;
    t_hash_rsp             hash_rsp;
    t_cnt_req              cnt_req;
    t_cnt_rsp              cnt_rsp;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_positions <= NP_W'(1024);
            r_num_hashes    <= NH_W'(4);
            r_key_length    <= KL_W'(32);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUM_POSITIONS: r_num_positions <= i_cfg.data[NP_W-1:0];
                CFG_NUM_HASHES:    r_num_hashes    <= i_cfg.data[NH_W-1:0];
                CFG_KEY_LENGTH:    r_key_length    <= i_cfg.data[KL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp out-of-range settings
    assign len_eff = (r_key_length > KL_W'(KEY_BITS)) ? KL_W'(KEY_BITS) : r_key_length;
    assign mod_eff = (r_num_positions == '0) ? MOD_W'(1) :
                     (MOD_W'(r_num_positions) > MOD_W'(NUM_COUNTERS)) ? MOD_W'(NUM_COUNTERS) :
                     MOD_W'(r_num_positions);
    assign k_eff   = (r_num_hashes == '0) ? NH_W'(1) :
                     (r_num_hashes > NH_W'(MAX_HASHES)) ? NH_W'(MAX_HASHES) : r_num_hashes;

    assign in_op    = t_opcode'(i_item.opcode);
    assign i_item.ready = (r_state == S_IDLE) && cnt_rsp.ready;
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign last_row = (NH_W'(r_row) == (r_k - NH_W'(1)));

    // Hash unit request
    assign hash_req.start   = (r_state == S_HSTART);
    assign hash_req.row     = r_row;
    assign hash_req.key     = r_key;
    assign hash_req.len     = len_eff;
    assign hash_req.modulus = mod_eff;
    assign hash_req.wr_en   = accept && (in_op == OP_LOAD);
    assign hash_req.wr_addr = {i_item.const_row, i_item.const_column};
    assign hash_req.wr_data = i_item.const_value;

    // Counter unit request
    always_comb begin
        cnt_req.valid = (r_state == S_CSTART);
        cnt_req.index = r_index;
        unique case (r_op)
            OP_ADD:   cnt_req.cmd = CNT_ADD;
            OP_QUERY: cnt_req.cmd = CNT_QUERY;
            default:  cnt_req.cmd = CNT_CLEAR;
        endcase
    end

    cbf_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hash_req),
        .o_rsp   (hash_rsp)
    );

    cbf_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cnt_req),
        .o_rsp   (cnt_rsp)
    );

    // Sequencer: add/query hash a row, then access its counter, row after row; clear goes straight to the counters
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_row   = r_row;
        n_k     = r_k;
        n_index = r_index;
        n_min   = r_min;
        n_nz    = r_nz;
        n_sat   = r_sat;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = in_op;
                    n_key = i_item.key_bits;
                    n_row = '0;
                    n_k   = k_eff;
                    n_min = COUNT_MAX;
                    n_nz  = '0;
                    n_sat = 1'b0;
                    if (in_op == OP_CLEAR) begin
                        n_state = S_CSTART;
                    end else if (in_op == OP_LOAD) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HSTART;
                    end
                end
            end
            S_HSTART: begin
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                if (hash_rsp.done) begin
                    n_index = hash_rsp.index;
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (r_op == OP_CLEAR) begin
                    if (cnt_rsp.ready) begin
                        n_state = S_DONE;
                    end
                end else if (cnt_rsp.done) begin
                    if (cnt_rsp.value < r_min) begin
                        n_min = cnt_rsp.value;
                    end
                    if (cnt_rsp.value != '0) begin
                        n_nz = r_nz + NZC_W'(1);
                    end
                    if (cnt_rsp.sat) begin
                        n_sat = 1'b1;
                    end
                    if (last_row) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_state = S_HSTART;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_row   <= n_row;
        r_k     <= n_k;
        r_index <= n_index;
        r_min   <= n_min;
        r_nz    <= n_nz;
        r_sat   <= n_sat;
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_present       <= (r_op == OP_QUERY) && (NH_W'(r_nz) == r_k);
            r_min_count     <= (r_op == OP_QUERY) ? MINC_W'(r_min) : '0;
            r_nonzero_count <= (r_op == OP_QUERY) ? r_nz : '0;
            r_saturated     <= (r_op == OP_ADD) && r_sat;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.present       = r_present;
    assign o_result.min_count     = r_min_count;
    assign o_result.nonzero_count = r_nonzero_count;
    assign o_result.saturated     = r_saturated;

endmodule
`default_nettype wire
